/* rtl/lisu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisu_pkg
// shared types and fixed constants of the linear interpolation upsampler
// ----------------------------------------------------------------------------
package lisu_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int SUM_W    = SAMPLE_W + 2;
    localparam int STEP_W   = 15;

    localparam logic [STEP_W-1:0] STEP_RESET = 15'd7526;

    localparam logic signed [SUM_W-1:0] SAT_MAX = 18'sd32767;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -18'sd32768;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

endpackage

/* rtl/linear_interp_stereo_upsampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_stereo_upsampler
// stereo linear interpolation sample rate converter with one shared multiplier
// ----------------------------------------------------------------------------
// Each accepted source frame (left in tdata[15:0], right in tdata[31:16]) is
// blended with the frame before it; the first frame after reset only loads
// the previous-frame store and gives no output. For each output a single
// shared multiplier forms the left product in ST_MUL_L and the right in
// ST_MUL_R, which also adds and saturates the left sum; ST_FIN does so for
// the right sum and loads the output register. A frame with k outputs
// repeats these states k times before the block idles. The last output of a
// frame carries tlast; the next frame is accepted while that output still
// waits in the output register. Back-pressure on the output side stretches ST_FIN.
// phase_step is written through cfg_wr_en/cfg_wr_data by the user only while
// idle, not enforced by the block; clamped to 2^PHASE_BITS/32..2^PHASE_BITS-1.
module linear_interp_stereo_upsampler #(
    parameter int PHASE_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,     // phase_step
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // left_in, right_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // left_out, right_out
    output logic        m_axis_tlast     // run_last
);

    localparam int SW     = ((PHASE_BITS > lisu_pkg::STEP_W) ? PHASE_BITS
                                                            : lisu_pkg::STEP_W) + 1;
    localparam int PROD_W = lisu_pkg::DIFF_W + PHASE_BITS + 1;
    localparam logic [SW-1:0] STEP_MIN = SW'(1) << (PHASE_BITS - 5);
    localparam logic [SW-1:0] STEP_MAX = (SW'(1) << PHASE_BITS) - SW'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN
    } state_t;

    state_t                        state_reg, state_next;
    logic                          primed_reg;
    logic [lisu_pkg::STEP_W-1:0]   step_reg;
    logic [PHASE_BITS-1:0]         phase_reg, phase_next;
    lisu_pkg::sample_t             prev_l_reg, prev_r_reg;
    lisu_pkg::sample_t             new_l_reg, new_r_reg;
    lisu_pkg::sample_t             res_l_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          out_valid_reg;
    logic                          out_last_reg;
    lisu_pkg::sample_t             out_l_reg, out_r_reg;

    logic [SW-1:0]                 step_ext;
    logic [PHASE_BITS-1:0]         step_eff;
    logic [PHASE_BITS:0]           phase_sum;
    logic                          run_end;
    logic                          in_beat;
    logic                          out_free;
    logic                          out_load;
    lisu_pkg::diff_t               mul_a;
    logic signed [PHASE_BITS:0]    mul_b;
    lisu_pkg::sample_t             add_base;
    logic signed [lisu_pkg::DIFF_W-1:0] quot;
    lisu_pkg::sum_t                sum;
    lisu_pkg::sample_t             sat;

    // step clamp
    always_comb
    begin
        step_ext = SW'(step_reg);
        if (step_ext < STEP_MIN)
        begin
            step_eff = PHASE_BITS'(STEP_MIN);
        end
        else if (step_ext > STEP_MAX)
        begin
            step_eff = PHASE_BITS'(STEP_MAX);
        end
        else
        begin
            step_eff = PHASE_BITS'(step_ext);
        end
    end

    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_eff};
    assign run_end   = phase_sum[PHASE_BITS];
    assign phase_next = phase_sum[PHASE_BITS-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_FIN) && out_free;

    // shared multiplier, left channel then right channel
    always_comb
    begin
        if (state_reg == ST_MUL_L)
        begin
            mul_a = lisu_pkg::DIFF_W'(new_l_reg) - lisu_pkg::DIFF_W'(prev_l_reg);
        end
        else
        begin
            mul_a = lisu_pkg::DIFF_W'(new_r_reg) - lisu_pkg::DIFF_W'(prev_r_reg);
        end
        mul_b = signed'({1'b0, phase_reg});
    end

    // add and saturate on the registered product
    always_comb
    begin
        add_base = (state_reg == ST_MUL_R) ? prev_l_reg : prev_r_reg;
        quot     = prod_reg[PHASE_BITS + lisu_pkg::SAMPLE_W : PHASE_BITS];
        sum      = lisu_pkg::SUM_W'(add_base) + lisu_pkg::SUM_W'(quot);
        if (sum > lisu_pkg::SAT_MAX)
        begin
            sat = lisu_pkg::SAMPLE_W'(lisu_pkg::SAT_MAX);
        end
        else if (sum < lisu_pkg::SAT_MIN)
        begin
            sat = lisu_pkg::SAMPLE_W'(lisu_pkg::SAT_MIN);
        end
        else
        begin
            sat = lisu_pkg::SAMPLE_W'(sum);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && primed_reg)
                begin
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = run_end ? ST_IDLE : ST_MUL_L;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            step_reg      <= lisu_pkg::STEP_RESET;
            phase_reg     <= '0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            new_l_reg     <= '0;
            new_r_reg     <= '0;
            res_l_reg     <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_l_reg     <= '0;
            out_r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                step_reg <= cfg_wr_data;
            end

            if (in_beat)
            begin
                if (!primed_reg)
                begin
                    prev_l_reg <= s_axis_tdata[15:0];
                    prev_r_reg <= s_axis_tdata[31:16];
                    primed_reg <= 1'b1;
                end
                else
                begin
                    new_l_reg <= s_axis_tdata[15:0];
                    new_r_reg <= s_axis_tdata[31:16];
                end
            end

            if ((state_reg == ST_MUL_L) || (state_reg == ST_MUL_R))
            begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            end

            if (state_reg == ST_MUL_R)
            begin
                res_l_reg <= sat;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= run_end;
                out_l_reg     <= res_l_reg;
                out_r_reg     <= sat;
                phase_reg     <= phase_next;
                if (run_end)
                begin
                    prev_l_reg <= new_l_reg;
                    prev_r_reg <= new_r_reg;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_r_reg, out_l_reg};

    a_primed_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && primed_reg) |=> (state_reg == ST_MUL_L))
        else $error("primed frame did not start the multiply sequence");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && run_end) |=> (state_reg == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
        else $error("last beat of a run did not return to idle");

    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_FIN))
        else $error("output beat raised outside the final step");

    a_prev_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_R) |-> ($stable(prev_l_reg) && $stable(prev_r_reg)))
        else $error("previous frame changed mid output");

endmodule
